>>> rtl/rcnh_pkg.sv
// shared constants, widths and types for the ray against cylinder nearest hit block
// no dependencies
package rcnh_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int INDEX_W   = 5;
    localparam int DIST_W    = 31;
    localparam int OPD_W     = 33;
    localparam int PROD_W    = 66;
    localparam int ACC_W     = 132;

    localparam int Q_W       = 128;
    localparam int ROOT_W    = 64;
    localparam int DEN_W     = 64;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = DEN_W + FRAC_W;

    // radius squared 1.5^2 at scale 2^-32
    localparam logic [64:0] RADIUS_SQ = 65'd9663676416;
    // cylinder spans 0.5 below to 1.5 above the slot height
    localparam logic signed [33:0] BELOW_Q = 34'sd32768;
    localparam logic signed [33:0] ABOVE_Q = 34'sd98304;

    // word operation codes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // multiply-accumulate command: load restarts the sum, sh picks 0, 32 or 64 bit shift
    typedef struct packed {
        logic       load;
        logic       sub;
        logic [1:0] sh;
    } t_mac_op;

endpackage

>>> rtl/rcnh_mac.sv
// shared signed multiply-accumulate unit, product registered before the wide add
// depends on rcnh_pkg
module rcnh_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_issue,
    input  rcnh_pkg::t_mac_op                    i_op,
    input  logic signed [rcnh_pkg::OPD_W-1:0]    i_a,
    input  logic signed [rcnh_pkg::OPD_W-1:0]    i_b,
    input  logic signed [rcnh_pkg::ACC_W-1:0]    i_init,
    output logic signed [rcnh_pkg::ACC_W-1:0]    o_acc
);
    import rcnh_pkg::*;

    logic                      r_vld;
    t_mac_op                   r_op;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_init;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   w_ext;
    logic signed [ACC_W-1:0]   w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_op   <= i_op;
            r_prod <= i_a * i_b;
            r_init <= i_init;
        end
    end

    always_comb begin
        w_ext  = ACC_W'(r_prod) <<< (32 * r_op.sh);
        w_base = r_op.load ? r_init : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_acc <= r_op.sub ? (w_base - w_ext) : (w_base + w_ext);
        end
    end

    assign o_acc = r_acc;

endmodule

>>> rtl/rcnh_sqrt.sv
// iterative integer square root, two radicand bits per cycle
// depends on rcnh_pkg
module rcnh_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rcnh_pkg::Q_W-1:0]      i_q,
    output logic                          o_done,
    output logic [rcnh_pkg::ROOT_W-1:0]   o_root
);
    import rcnh_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [Q_W-1:0]      r_q;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W+1:0]   w_rem2;
    logic [ROOT_W+1:0]   w_trial;
    logic                w_ge;
    logic                w_last;

    always_comb begin
        w_rem2  = {r_rem[ROOT_W-1:0], r_q[Q_W-1 -: 2]};
        w_trial = {r_root, 2'b01};
        w_ge    = w_rem2 >= w_trial;
        w_last  = r_cnt == CNT_W'(ROOT_W - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_q;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_q    <= r_q << 2;
            r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> rtl/rcnh_div.sv
// restoring divider, one quotient bit per cycle, floor(num * 2^16 / den)
// depends on rcnh_pkg
module rcnh_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rcnh_pkg::ROOT_W-1:0]   i_num,
    input  logic [rcnh_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [rcnh_pkg::QUO_W-1:0]    o_quo
);
    import rcnh_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [QUO_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W:0]     r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [DEN_W:0]     w_rem2;
    logic               w_ge;
    logic               w_last;

    always_comb begin
        w_rem2 = {r_rem[DEN_W-1:0], r_num[QUO_W-1]};
        w_ge   = w_rem2 >= {1'b0, r_den};
        w_last = r_cnt == CNT_W'(QUO_W - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_num, {FRAC_W{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/ray_cylinder_nearest_hit.sv
// top level: slot table, query sequencer and the shared arithmetic units
// depends on rcnh_pkg, rcnh_mac, rcnh_sqrt, rcnh_div
module ray_cylinder_nearest_hit #(
    parameter int SLOTS = rcnh_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              o_done,
    input  logic                              i_operation,
    input  logic [rcnh_pkg::INDEX_W-1:0]      i_slot,
    input  logic                              i_valid_req,
    input  logic signed [rcnh_pkg::DATA_W-1:0] i_point_x,
    input  logic signed [rcnh_pkg::DATA_W-1:0] i_point_y,
    input  logic signed [rcnh_pkg::DATA_W-1:0] i_point_z,
    input  logic signed [rcnh_pkg::DATA_W-1:0] i_dir_x,
    input  logic signed [rcnh_pkg::DATA_W-1:0] i_dir_y,
    input  logic signed [rcnh_pkg::DATA_W-1:0] i_dir_z,
    input  logic [rcnh_pkg::DIST_W-1:0]       i_max_distance,
    output logic                              o_hit,
    output logic [rcnh_pkg::INDEX_W-1:0]      o_hit_index,
    output logic [rcnh_pkg::DIST_W-1:0]       o_hit_distance
);
    // a word is taken when start is high and busy is low. a write word (operation 0)
    // fills one slot in that cycle and gives no result; busy stays low. a query word
    // (operation 1) raises busy and walks every slot, handing the valid ones to one
    // shared multiply-accumulate unit, an iterative square root and an iterative
    // divider; an empty slot is skipped without using them. a degenerate horizontal
    // direction ends the query before any slot is visited. the result is shown for
    // exactly one cycle with o_done high, the cycle in which busy has just dropped; the
    // receiver cannot hold it off, so it must take the word in that cycle

    import rcnh_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MAC  = 10'b0000000010,
        S_READ = 10'b0000000100,
        S_OFF  = 10'b0000001000,
        S_CHK  = 10'b0000010000,
        S_SQRT = 10'b0000100000,
        S_DIV  = 10'b0001000000,
        S_NEXT = 10'b0010000000,
        S_DONE = 10'b0100000000,
        S_WAIT = 10'b1000000000
    } t_state;

    typedef enum logic [2:0] {
        PH_A    = 3'd0,
        PH_NEGH = 3'd1,
        PH_SUM  = 3'd2,
        PH_Q    = 3'd3,
        PH_HY   = 3'd4
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    logic [3:0] r_cnt;

    // slot table
    logic [SLOTS-1:0]        r_valid;
    logic [3*DATA_W-1:0]     mem [SLOTS];
    logic [3*DATA_W-1:0]     r_rd;
    logic [IDX_W-1:0]        r_slot;

    // query word
    logic signed [DATA_W-1:0] r_ox, r_oy, r_oz, r_dx, r_dy, r_dz;
    logic [DIST_W-1:0]        r_best;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_found;

    // per query and per slot intermediates
    logic [DEN_W-1:0]         r_a;
    logic signed [DATA_W-1:0] r_rx, r_rz;
    logic                     r_nh_neg;
    logic [ROOT_W-1:0]        r_nh_mag;
    logic                     r_cr_neg;
    logic [ROOT_W-1:0]        r_cr_mag;
    logic                     r_q_neg;
    logic [Q_W-1:0]           r_q;
    logic [DIST_W-1:0]        r_t;

    logic                     r_done;
    logic                     r_hit;
    logic [INDEX_W-1:0]       r_hit_index;
    logic [DIST_W-1:0]        r_hit_distance;

    logic                     w_accept;
    logic                     w_wr;
    logic [IDX_W-1:0]         w_wr_idx;
    logic [3:0]               w_len;
    logic                     w_issue;
    logic                     w_capture;
    t_mac_op                  w_op;
    logic signed [OPD_W-1:0]  w_a, w_b;
    logic signed [ACC_W-1:0]  w_init;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [64:0]       w_negh;
    logic signed [64:0]       w_cr;
    logic signed [DATA_W:0]   w_dxo, w_dzo;
    logic signed [33:0]       w_py_lo, w_py_hi;
    logic signed [ACC_W-1:0]  w_lo, w_hi;
    logic                     w_in_height;
    logic                     w_sq_start, w_sq_done;
    logic [ROOT_W-1:0]        w_root;
    logic                     w_dv_start, w_dv_done;
    logic [QUO_W-1:0]         w_quo;
    logic                     w_last_slot;

    assign w_accept = start && !busy;
    assign w_wr     = w_accept && (i_operation == OP_WRITE) && (int'(i_slot) < SLOTS);
    assign w_wr_idx = IDX_W'(i_slot);
    assign w_last_slot = r_slot == IDX_W'(SLOTS - 1);

    // micro-programme lengths per phase
    always_comb begin
        unique case (r_phase)
            PH_A:    w_len = 4'd2;
            PH_NEGH: w_len = 4'd2;
            PH_SUM:  w_len = 4'd2;
            PH_Q:    w_len = 4'd8;
            PH_HY:   w_len = 4'd1;
            default: w_len = 4'd1;
        endcase
    end

    assign w_issue   = (r_state == S_MAC) && (r_cnt < w_len);
    // capture once the last issue has passed the product and accumulator registers
    assign w_capture = (r_state == S_MAC) && (r_cnt == w_len + 4'd1);

    // operand selection for the shared multiply-accumulate unit
    always_comb begin
        w_op   = '{load: 1'b0, sub: 1'b0, sh: 2'd0};
        w_a    = '0;
        w_b    = '0;
        w_init = '0;
        unique case (r_phase)
            PH_A: begin
                w_op.load = r_cnt == 4'd0;
                w_a = (r_cnt == 4'd0) ? {r_dx[DATA_W-1], r_dx} : {r_dz[DATA_W-1], r_dz};
                w_b = w_a;
            end
            PH_NEGH: begin
                w_op.load = r_cnt == 4'd0;
                w_op.sub  = 1'b1;
                w_a = (r_cnt == 4'd0) ? {r_rx[DATA_W-1], r_rx} : {r_rz[DATA_W-1], r_rz};
                w_b = (r_cnt == 4'd0) ? {r_dx[DATA_W-1], r_dx} : {r_dz[DATA_W-1], r_dz};
            end
            PH_SUM: begin
                w_op.load = r_cnt == 4'd0;
                w_a = (r_cnt == 4'd0) ? {r_rx[DATA_W-1], r_rx} : {r_rz[DATA_W-1], r_rz};
                w_b = w_a;
            end
            PH_Q: begin
                // negh^2 minus a times (sum - r^2), built from 32 bit limbs
                unique case (r_cnt[2:0])
                    3'd0: begin
                        w_op = '{load: 1'b1, sub: 1'b0, sh: 2'd0};
                        w_a = {1'b0, r_nh_mag[31:0]};
                        w_b = {1'b0, r_nh_mag[31:0]};
                    end
                    3'd1, 3'd2: begin
                        w_op = '{load: 1'b0, sub: 1'b0, sh: 2'd1};
                        w_a = {1'b0, r_nh_mag[31:0]};
                        w_b = {1'b0, r_nh_mag[63:32]};
                    end
                    3'd3: begin
                        w_op = '{load: 1'b0, sub: 1'b0, sh: 2'd2};
                        w_a = {1'b0, r_nh_mag[63:32]};
                        w_b = {1'b0, r_nh_mag[63:32]};
                    end
                    3'd4: begin
                        w_op = '{load: 1'b0, sub: !r_cr_neg, sh: 2'd0};
                        w_a = {1'b0, r_a[31:0]};
                        w_b = {1'b0, r_cr_mag[31:0]};
                    end
                    3'd5: begin
                        w_op = '{load: 1'b0, sub: !r_cr_neg, sh: 2'd1};
                        w_a = {1'b0, r_a[31:0]};
                        w_b = {1'b0, r_cr_mag[63:32]};
                    end
                    3'd6: begin
                        w_op = '{load: 1'b0, sub: !r_cr_neg, sh: 2'd1};
                        w_a = {1'b0, r_a[63:32]};
                        w_b = {1'b0, r_cr_mag[31:0]};
                    end
                    3'd7: begin
                        w_op = '{load: 1'b0, sub: !r_cr_neg, sh: 2'd2};
                        w_a = {1'b0, r_a[63:32]};
                        w_b = {1'b0, r_cr_mag[63:32]};
                    end
                    default: ;
                endcase
            end
            PH_HY: begin
                // hit height: origin y scaled up plus dir y times t
                w_op.load = 1'b1;
                w_a    = {r_dy[DATA_W-1], r_dy};
                w_b    = {2'b00, r_t};
                w_init = {{(ACC_W-DATA_W-FRAC_W){r_oy[DATA_W-1]}}, r_oy, {FRAC_W{1'b0}}};
            end
            default: ;
        endcase
    end

    rcnh_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_init  (w_init),
        .o_acc   (w_acc)
    );

    assign w_sq_start = (r_state == S_CHK) && !r_q_neg && !r_nh_neg;

    rcnh_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_q     (r_q),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // behind the origin when the root exceeds -h
    assign w_dv_start = (r_state == S_SQRT) && w_sq_done && !(w_root > r_nh_mag);

    rcnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (r_nh_mag - w_root),
        .i_den   (r_a),
        .o_done  (w_dv_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_negh  = w_acc[64:0];
        w_cr    = $signed({1'b0, w_acc[63:0]}) - $signed(RADIUS_SQ);
        w_dxo   = {r_ox[DATA_W-1], r_ox} - {r_rd[3*DATA_W-1], r_rd[3*DATA_W-1 -: DATA_W]};
        w_dzo   = {r_oz[DATA_W-1], r_oz} - {r_rd[DATA_W-1], r_rd[DATA_W-1:0]};
        w_py_lo = {{2{r_rd[2*DATA_W-1]}}, r_rd[2*DATA_W-1 -: DATA_W]} - BELOW_Q;
        w_py_hi = {{2{r_rd[2*DATA_W-1]}}, r_rd[2*DATA_W-1 -: DATA_W]} + ABOVE_Q;
        w_lo    = {{(ACC_W-34-FRAC_W){w_py_lo[33]}}, w_py_lo, {FRAC_W{1'b0}}};
        w_hi    = {{(ACC_W-34-FRAC_W){w_py_hi[33]}}, w_py_hi, {FRAC_W{1'b0}}};
        w_in_height = (w_acc >= w_lo) && (w_acc <= w_hi);
    end

    // slot table storage; position read follows the slot pointer
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[w_wr_idx] <= {i_point_x, i_point_y, i_point_z};
        end
        r_rd <= mem[r_slot];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_A;
            r_cnt   <= '0;
            r_valid <= '0;
            r_slot  <= '0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            // result strobe registered from the done state
            r_done <= r_state == S_DONE;
            if (w_wr) begin
                r_valid[w_wr_idx] <= i_valid_req;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_operation == OP_QUERY)) begin
                        r_found <= 1'b0;
                        r_phase <= PH_A;
                        r_cnt   <= '0;
                        r_slot  <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_cnt <= w_capture ? 4'd0 : r_cnt + 4'd1;
                    if (w_capture) begin
                        unique case (r_phase)
                            PH_A: begin
                                // horizontal a below one lsb rejects every slot
                                r_state <= (w_acc[63:FRAC_W] == '0) ? S_DONE : S_READ;
                            end
                            PH_NEGH: r_phase <= PH_SUM;
                            PH_SUM:  r_phase <= PH_Q;
                            PH_Q:    r_state <= S_CHK;
                            PH_HY: begin
                                if (w_in_height) begin
                                    r_found <= 1'b1;
                                end
                                r_state <= S_NEXT;
                            end
                            default: r_state <= S_NEXT;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= r_valid[r_slot] ? S_WAIT : S_NEXT;
                end
                S_WAIT: begin
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    r_phase <= PH_NEGH;
                    r_cnt   <= '0;
                    r_state <= S_MAC;
                end
                S_CHK: begin
                    r_state <= w_sq_start ? S_SQRT : S_NEXT;
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_state <= w_dv_start ? S_DIV : S_NEXT;
                    end
                end
                S_DIV: begin
                    if (w_dv_done) begin
                        if (w_quo > QUO_W'(r_best)) begin
                            r_state <= S_NEXT;
                        end else begin
                            r_phase <= PH_HY;
                            r_cnt   <= '0;
                            r_state <= S_MAC;
                        end
                    end
                end
                S_NEXT: begin
                    if (w_last_slot) begin
                        r_state <= S_DONE;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_operation == OP_QUERY)) begin
            r_ox   <= i_point_x;
            r_oy   <= i_point_y;
            r_oz   <= i_point_z;
            r_dx   <= i_dir_x;
            r_dy   <= i_dir_y;
            r_dz   <= i_dir_z;
            r_best <= i_max_distance;
            r_idx  <= '0;
        end
        if (r_state == S_OFF) begin
            // offsets saturate to the q16.16 range
            r_rx <= (w_dxo[DATA_W] != w_dxo[DATA_W-1]) ?
                    {w_dxo[DATA_W], {(DATA_W-1){!w_dxo[DATA_W]}}} : w_dxo[DATA_W-1:0];
            r_rz <= (w_dzo[DATA_W] != w_dzo[DATA_W-1]) ?
                    {w_dzo[DATA_W], {(DATA_W-1){!w_dzo[DATA_W]}}} : w_dzo[DATA_W-1:0];
        end
        if (w_capture) begin
            unique case (r_phase)
                PH_A: r_a <= w_acc[63:0];
                PH_NEGH: begin
                    r_nh_neg <= w_negh[64];
                    r_nh_mag <= w_negh[64] ? 64'(-w_negh) : w_negh[63:0];
                end
                PH_SUM: begin
                    r_cr_neg <= w_cr[64];
                    r_cr_mag <= w_cr[64] ? 64'(-w_cr) : w_cr[63:0];
                end
                PH_Q: begin
                    r_q_neg <= w_acc[ACC_W-1];
                    r_q     <= w_acc[Q_W-1:0];
                end
                PH_HY: begin
                    // equal distance replaces, so ties go to the later slot
                    if (w_in_height) begin
                        r_best <= r_t;
                        r_idx  <= r_slot;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_DIV && w_dv_done) begin
            r_t <= w_quo[DIST_W-1:0];
        end
        if (r_state == S_DONE) begin
            r_hit          <= r_found;
            r_hit_index    <= INDEX_W'(r_idx);
            r_hit_distance <= r_best;
        end
    end

    assign busy           = r_state != S_IDLE;
    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_hit_index    = r_hit_index;
    assign o_hit_distance = r_hit_distance;

endmodule

>>> bench/tb_top.sv
// self-checking bench for ray_cylinder_nearest_hit: slot writes and ray queries
// depends on rcnh_pkg and the ray_cylinder_nearest_hit rtl
`timescale 1ns / 1ps

module tb_top;
    import rcnh_pkg::*;

    localparam int U          = 65536;     // one unit in Q16.16
    localparam int MAX_RANGE  = 32'h7FFF_FFFF;
    localparam int IDLE_LIMIT = 200000;    // cycles with no handshake and no result
    localparam int TAIL_WAIT  = 64;

    typedef struct {
        t_op                       op;
        logic [INDEX_W-1:0]        slot;
        logic                      vreq;
        logic signed [DATA_W-1:0]  px, py, pz;
        logic signed [DATA_W-1:0]  dx, dy, dz;
        logic [DIST_W-1:0]         maxd;
    } t_word;

    typedef struct {
        logic                hit;
        logic [INDEX_W-1:0]  idx;
        logic [DIST_W-1:0]   hit_dist;
    } t_hit;

    // keeps its own copy of the target table and the queue of expected answers
    class t_cyl_hit_tracker;
        bit                       tab_valid [SLOTS_DEF];
        logic signed [DATA_W-1:0] tab_x [SLOTS_DEF];
        logic signed [DATA_W-1:0] tab_y [SLOTS_DEF];
        logic signed [DATA_W-1:0] tab_z [SLOTS_DEF];
        t_hit                     expected_hits [$];
        int                       errs;

        function new();
            errs = 0;
            foreach (tab_valid[i]) tab_valid[i] = 0;
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errs++;
        endtask

        function t_hit nearest_hit(t_word w);
            logic signed [131:0] ox, oy, oz, dx, dy, dz, rx, rz;
            logic signed [131:0] a, negh, sum, q, s, c, t, hy, best;
            t_hit r;
            best  = w.maxd;
            r.hit = 0;
            r.idx = '0;
            ox = w.px; oy = w.py; oz = w.pz;
            dx = w.dx; dy = w.dy; dz = w.dz;
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (!tab_valid[i]) continue;
                rx = ox - tab_x[i];
                rz = oz - tab_z[i];
                // horizontal offset saturates to Q16.16
                if (rx > 132'sd2147483647) rx = 132'sd2147483647;
                if (rx < -132'sd2147483648) rx = -132'sd2147483648;
                if (rz > 132'sd2147483647) rz = 132'sd2147483647;
                if (rz < -132'sd2147483648) rz = -132'sd2147483648;
                a = dx * dx + dz * dz;
                if (a < 65536) continue;
                negh = -(rx * dx) - (rz * dz);
                sum  = rx * rx + rz * rz;
                q    = negh * negh - a * (sum - 132'sd9663676416);
                if (q < 0 || negh < 0) continue;
                s = 0;
                for (int b = 63; b >= 0; b--) begin
                    c = s | (132'sd1 << b);
                    if (c * c <= q) s = c;
                end
                if (s > negh) continue;
                t = ((negh - s) * 65536) / a;
                if (t > best) continue;
                hy = oy * 65536 + dy * t;
                if (hy < (tab_y[i] - 32768) * 65536) continue;
                if (hy > (tab_y[i] + 98304) * 65536) continue;
                best  = t;
                r.idx = INDEX_W'(i);
                r.hit = 1;
            end
            r.hit_dist = best[DIST_W-1:0];
            return r;
        endfunction

        function void note_word(t_word w);
            if (w.op == OP_WRITE) begin
                tab_valid[w.slot] = w.vreq;
                tab_x[w.slot] = w.px;
                tab_y[w.slot] = w.py;
                tab_z[w.slot] = w.pz;
            end else begin
                expected_hits.push_back(nearest_hit(w));
            end
        endfunction

        task check_word(logic hit, logic [INDEX_W-1:0] idx, logic [DIST_W-1:0] hit_dist);
            t_hit e;
            if (expected_hits.size() == 0) begin
                report($sformatf("unexpected result hit=%0d idx=%0d hit_distance=%0h",
                                 hit, idx, hit_dist));
            end else begin
                e = expected_hits.pop_front();
                if (hit !== e.hit)
                    report($sformatf("hit %0d, expected %0d", hit, e.hit));
                if (idx !== e.idx)
                    report($sformatf("hit_index %0d, expected %0d", idx, e.idx));
                if (hit_dist !== e.hit_dist)
                    report($sformatf("hit_distance %0h, expected %0h", hit_dist,
                                     e.hit_dist));
            end
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      o_done;
    logic                      i_operation;
    logic [INDEX_W-1:0]        i_slot;
    logic                      i_valid_req;
    logic signed [DATA_W-1:0]  i_point_x, i_point_y, i_point_z;
    logic signed [DATA_W-1:0]  i_dir_x, i_dir_y, i_dir_z;
    logic [DIST_W-1:0]         i_max_distance;
    logic                      o_hit;
    logic [INDEX_W-1:0]        o_hit_index;
    logic [DIST_W-1:0]         o_hit_distance;

    t_cyl_hit_tracker tracker;
    int               idle_cycles;

    // stimulus-side view of the table, used to aim rays at real targets
    bit scene_valid [SLOTS_DEF];
    int scene_x [SLOTS_DEF];
    int scene_y [SLOTS_DEF];
    int scene_z [SLOTS_DEF];

    ray_cylinder_nearest_hit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_done         (o_done),
        .i_operation    (i_operation),
        .i_slot         (i_slot),
        .i_valid_req    (i_valid_req),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .i_max_distance (i_max_distance),
        .o_hit          (o_hit),
        .o_hit_index    (o_hit_index),
        .o_hit_distance (o_hit_distance)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // results are strobed for one cycle and cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tracker.check_word(o_hit, o_hit_index, o_hit_distance);
    end

    // watchdog: any handshake or result clears the idle count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_word mk_write(int slot, bit v, int x, int y, int z);
        t_word w;
        w.op = OP_WRITE; w.slot = INDEX_W'(slot); w.vreq = v;
        w.px = x; w.py = y; w.pz = z;
        w.dx = $urandom; w.dy = $urandom; w.dz = $urandom;
        w.maxd = DIST_W'($urandom);
        return w;
    endfunction

    function automatic t_word mk_query(int x, int y, int z, int dx, int dy, int dz,
                                       int maxd);
        t_word w;
        w.op = OP_QUERY; w.slot = INDEX_W'($urandom); w.vreq = 1'($urandom);
        w.px = x; w.py = y; w.pz = z;
        w.dx = dx; w.dy = dy; w.dz = dz;
        w.maxd = DIST_W'(maxd);
        return w;
    endfunction

    // present one word after a gap; start stays high across back-to-back words
    task automatic send_word(t_word w, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation    <= w.op;
        i_slot         <= w.slot;
        i_valid_req    <= w.vreq;
        i_point_x      <= w.px;
        i_point_y      <= w.py;
        i_point_z      <= w.pz;
        i_dir_x        <= w.dx;
        i_dir_y        <= w.dy;
        i_dir_z        <= w.dz;
        i_max_distance <= w.maxd;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy);
        tracker.note_word(w);
        if (w.op == OP_WRITE) begin
            scene_valid[w.slot] = w.vreq;
            scene_x[w.slot] = w.px;
            scene_y[w.slot] = w.py;
            scene_z[w.slot] = w.pz;
        end
    endtask

    // ray from a random spot near a valid target, pointed roughly at it
    function automatic t_word aimed_query();
        int k, ox, oy, oz, sh;
        int md;
        k = $urandom_range(0, SLOTS_DEF - 1);
        for (int n = 0; n < SLOTS_DEF && !scene_valid[k]; n++)
            k = (k + 1) % SLOTS_DEF;
        ox = scene_x[k] + $urandom_range(0, 40 * U) - 20 * U;
        oz = scene_z[k] + $urandom_range(0, 40 * U) - 20 * U;
        oy = scene_y[k] + $urandom_range(0, 3 * U) - U;
        sh = $urandom_range(0, 4);
        case ($urandom_range(0, 3))
            0: md = MAX_RANGE;
            1: md = $urandom_range(0, 4 * U);
            default: md = $urandom_range(0, 64 * U);
        endcase
        return mk_query(ox, oy, oz,
                        ((scene_x[k] - ox) >>> sh) + $signed($urandom_range(0, U / 2))
                            - U / 4,
                        $urandom_range(0, U / 4) - U / 8,
                        ((scene_z[k] - oz) >>> sh) + $signed($urandom_range(0, U / 2))
                            - U / 4,
                        md);
    endfunction

    initial begin
        t_word w;
        int    r, gap;
        bit    no_gaps;

        tracker = new();
        foreach (scene_valid[i]) scene_valid[i] = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = OP_WRITE;
        i_slot = '0;
        i_valid_req = 1'b0;
        i_point_x = '0; i_point_y = '0; i_point_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        i_max_distance = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        send_word(mk_query(0, 0, 0, U, 0, 0, MAX_RANGE), 0);                // empty table
        send_word(mk_write(0, 1, 0, 0, 0), 1);
        send_word(mk_write(31, 1, 10 * U, 0, 0), 0);
        send_word(mk_write(3, 1, 5 * U, 0, 5 * U), 2);
        send_word(mk_write(7, 1, 5 * U, 0, 5 * U), 0);                      // same spot as 3
        send_word(mk_write(1, 0, 32'sh7FFF_FFFF, -32'sh8000_0000, -1), 0); // not a target
        send_word(mk_query(-10 * U, U / 2, 0, U, 0, 0, MAX_RANGE), 0);      // nearest is slot 0
        send_word(mk_query(-10 * U, U / 2, 0, -U, 0, 0, MAX_RANGE), 3);     // target behind
        send_word(mk_query(-10 * U, U / 2, 0, 0, U, 0, MAX_RANGE), 0);      // degenerate dir
        send_word(mk_query(-10 * U, U / 2, 0, 100, 0, 100, MAX_RANGE), 0);
        send_word(mk_query(5 * U, U / 2, -10 * U, 0, 0, U, MAX_RANGE), 1);  // tie 3 and 7
        send_word(mk_query(-10 * U, U / 2, 0, U, 0, 0, 0), 0);              // zero range
        send_word(mk_query(-10 * U, U / 2, 0, U, 0, 0, 17 * U / 2), 0);     // range at the wall
        send_word(mk_query(0, U / 2, 0, U, 0, 0, MAX_RANGE), 0);            // start inside
        send_word(mk_query(-10 * U, 5 * U, 0, U, 0, 0, MAX_RANGE), 0);      // above cylinder
        send_word(mk_query(-10 * U, -U, 0, U, 0, 0, MAX_RANGE), 0);         // below cylinder
        send_word(mk_query(-10 * U, 3 * U, 0, U, -U / 4, 0, MAX_RANGE), 0); // slanted
        send_word(mk_query(32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, -32'sh8000_0000, 0,
                           -32'sh8000_0000, MAX_RANGE), 2);                 // far origin
        send_word(mk_write(2, 1, -32'sh8000_0000, 0, -32'sh8000_0000), 0);
        send_word(mk_query(32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, -U, 0, -U, MAX_RANGE), 0);
        send_word(mk_query(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                           32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           MAX_RANGE), 0);
        send_word(mk_query(-1, -1, -1, -1, -1, -1, MAX_RANGE), 0);

        // random part: mostly real targets and aimed rays, some raw noise
        no_gaps = 0;
        for (int n = 0; n < 580; n++) begin
            if (n % 60 == 0) no_gaps = $urandom_range(0, 2) == 0;
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                w = mk_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom);
                w.op = t_op'($urandom_range(0, 1));
                w.slot = INDEX_W'($urandom);
                w.vreq = 1'($urandom);
            end else if (r < 40) begin
                w = mk_write($urandom_range(0, SLOTS_DEF - 1), $urandom_range(0, 4) != 0,
                             $urandom_range(0, 60 * U) - 30 * U,
                             $urandom_range(0, 4 * U) - 2 * U,
                             $urandom_range(0, 60 * U) - 30 * U);
            end else if (r < 48) begin
                w = mk_query($urandom_range(0, 60 * U) - 30 * U, $urandom_range(0, 2 * U),
                             $urandom_range(0, 60 * U) - 30 * U,
                             $urandom, $urandom, $urandom, $urandom);
            end else begin
                w = aimed_query();
            end
            send_word(w, gap);
        end
        start <= 1'b0;

        while (tracker.expected_hits.size() > 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (tracker.expected_hits.size() > 0)
            tracker.report($sformatf("%0d results never arrived",
                                     tracker.expected_hits.size()));
        if (tracker.errs == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
